>>> rtl/core/membrane_crossing_tracker_defines.svh
// assertion macros for the membrane crossing tracker
`ifndef MEMBRANE_CROSSING_TRACKER_DEFINES_SVH
`define MEMBRANE_CROSSING_TRACKER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MCT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define MCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/mct_pkg.sv
// types and constants of the membrane crossing tracker
package mct_pkg;

	localparam int MAX_PARTICLES_DEF = 4096;
	localparam int INDEX_W = 12;
	localparam int IDENT_W = 24;
	localparam int Z_W = 24;
	localparam int FRAME_W = 24;
	localparam int LIMIT_W = 23;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;
	localparam int ENTRY_W = FRAME_W + 2;

	localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};
	localparam logic [LIMIT_W-1:0] INNER_RESET = 23'd2560;
	localparam logic [LIMIT_W-1:0] OUTER_RESET = 23'd5120;

	localparam logic REG_INNER = 1'b0;
	localparam logic REG_OUTER = 1'b1;

	typedef struct packed {
		logic [INDEX_W-1:0] particle_index;
		logic [IDENT_W-1:0] particle_ident;
		logic signed [Z_W-1:0] z_pos;
		logic frame_end;
	} item_t;

	typedef struct packed {
		logic [IDENT_W-1:0] crossed_ident;
		logic [FRAME_W-1:0] lifetime_frames;
		logic [FRAME_W-1:0] entry_frame_out;
		logic [FRAME_W-1:0] exit_frame_out;
		logic exit_positive;
	} result_t;

	// table entry: in-zone flag, entry side, entry frame
	typedef struct packed {
		logic in_zone;
		logic side_pos;
		logic [FRAME_W-1:0] frame;
	} entry_t;

endpackage

>>> rtl/core/membrane_crossing_tracker.sv
// membrane crossing tracker top level: per-particle hysteresis table and frame counter
//
// Items enter on item/item_valid/item_stall and results leave on
// result/result_valid/result_stall; an item moves when valid is high and
// stall is low. A frame-end item advances the saturating frame counter; a
// particle item updates its table slot and may yield one crossing result.
// Thresholds are written over the APB port (inner at 0, outer at 4).
// The table stage registers each result in the output register. Throughput is
// one item per cycle unless result_stall or the clearing pass holds it: the
// table is one memory with a registered read, read on accept and written back
// from the table stage, with a forwarding path when consecutive items hit the
// same slot. After reset a clearing pass writes every table entry to zero, one
// per cycle; item_stall stays high during it while register writes are still
// taken. When result_stall holds a full output register, a waiting item stays
// in the table stage and item_stall rises until it drains.
`include "membrane_crossing_tracker_defines.svh"

module membrane_crossing_tracker #(
	parameter int MAX_PARTICLES = mct_pkg::MAX_PARTICLES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mct_pkg::ADDR_W-1:0] paddr,
	input  logic [mct_pkg::DATA_W-1:0] pwdata,
	output logic [mct_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  mct_pkg::item_t             item,
	input  logic                       item_valid,
	output logic                       item_stall,
	output mct_pkg::result_t           result,
	output logic                       result_valid,
	input  logic                       result_stall
);

	localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CMP_W = 17;

	logic [mct_pkg::LIMIT_W-1:0] inner_q, outer_q;
	logic [mct_pkg::FRAME_W-1:0] frame_counter_q;
	logic clearing_q;
	logic [IDX_W-1:0] clr_addr_q;

	mct_pkg::entry_t mem [MAX_PARTICLES];
	mct_pkg::entry_t rd_data_q;

	logic valid_s1;
	logic fwd_hit_s1;
	mct_pkg::entry_t fwd_data_s1;
	mct_pkg::item_t item_s1;
	logic [IDX_W-1:0] slot_s1;
	logic in_range_s1;
	logic [mct_pkg::FRAME_W-1:0] frame_s1;

	logic out_valid_q;
	mct_pkg::result_t out_q;

	logic accept, s1_go, in_range;
	logic [IDX_W-1:0] in_slot;
	mct_pkg::entry_t ent, upd_wr_data, wr_data;
	logic upd_wr, emit, wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic z_neg, positive;
	logic [mct_pkg::Z_W-1:0] z_u, mag;
	logic cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= mct_pkg::INNER_RESET;
			outer_q <= mct_pkg::OUTER_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				mct_pkg::REG_INNER: inner_q <= pwdata[mct_pkg::LIMIT_W-1:0];
				mct_pkg::REG_OUTER: outer_q <= pwdata[mct_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			mct_pkg::REG_INNER: prdata = mct_pkg::DATA_W'(inner_q);
			mct_pkg::REG_OUTER: prdata = mct_pkg::DATA_W'(outer_q);
			default: prdata = '0;
		endcase
	end

	// handshake
	assign s1_go = !(out_valid_q && result_stall);
	assign item_stall = clearing_q || (valid_s1 && !s1_go);
	assign accept = item_valid && !item_stall;
	assign in_range = ({(CMP_W - mct_pkg::INDEX_W)'(0), item.particle_index}
		< CMP_W'(MAX_PARTICLES));
	assign in_slot = IDX_W'(item.particle_index);

	// frame counter and clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_counter_q <= '0;
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (accept && item.frame_end && frame_counter_q != mct_pkg::FRAME_MAX)
				frame_counter_q <= frame_counter_q + 1'b1;
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == IDX_W'(MAX_PARTICLES - 1))
					clearing_q <= 1'b0;
			end
		end
	end

	// table stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
			slot_s1 <= in_slot;
			in_range_s1 <= in_range;
			frame_s1 <= frame_counter_q;
			fwd_hit_s1 <= wr_en && (wr_addr == in_slot);
			fwd_data_s1 <= wr_data;
		end
	end

	always_comb begin
		ent = fwd_hit_s1 ? fwd_data_s1 : rd_data_q;
		z_u = item_s1.z_pos;
		z_neg = z_u[mct_pkg::Z_W-1];
		positive = !z_neg && (z_u != '0);
		mag = z_neg ? (~z_u + 1'b1) : z_u;
		upd_wr = 1'b0;
		emit = 1'b0;
		upd_wr_data = ent;
		if (valid_s1 && s1_go && !item_s1.frame_end && in_range_s1) begin
			if (!ent.in_zone) begin
				if (mag < mct_pkg::Z_W'(inner_q)) begin
					upd_wr = 1'b1;
					upd_wr_data.in_zone = 1'b1;
					upd_wr_data.side_pos = positive;
					upd_wr_data.frame = frame_s1;
				end
			end else if (mag >= mct_pkg::Z_W'(outer_q)) begin
				upd_wr = 1'b1;
				upd_wr_data.in_zone = 1'b0;
				emit = (ent.side_pos != positive);
			end
		end
	end

	assign wr_en = clearing_q || upd_wr;
	assign wr_addr = clearing_q ? clr_addr_q : slot_s1;
	assign wr_data = clearing_q ? mct_pkg::entry_t'('0) : upd_wr_data;

	// table memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (accept)
			rd_data_q <= mem[in_slot];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.crossed_ident <= item_s1.particle_ident;
			out_q.lifetime_frames <= frame_s1 - ent.frame;
			out_q.entry_frame_out <= ent.frame;
			out_q.exit_frame_out <= frame_s1;
			out_q.exit_positive <= positive;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

	`MCT_ASSERT_NOW(a_no_accept_clearing, clearing_q, item_stall, "item accepted during clear")
	`MCT_ASSERT_NOW(a_clear_excl, clearing_q, !upd_wr, "table update during clear")
	`MCT_ASSERT_NEXT(a_frame_sat, frame_counter_q == mct_pkg::FRAME_MAX,
		frame_counter_q == mct_pkg::FRAME_MAX, "frame counter wrapped")
	`MCT_ASSERT_NEXT(a_result_src, !out_valid_q,
		!out_valid_q || $past(valid_s1 && s1_go), "result without table stage")

endmodule
